### hdl/cwda_pkg.sv
// Shared constants, input kind codes and memory port structs for the CSR diagonal block.
package cwda_pkg;

  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 8192;

  localparam int KIND_W = 3;
  localparam int IDX_W  = 14;
  localparam int WGT_W  = 32;
  localparam int ROW_W  = 10;
  localparam int ACC_W  = 48;

  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int RP_AW   = $clog2(MAX_NODES + 1);
  localparam int EDGE_AW = $clog2(MAX_EDGES);
  localparam int WR_AW   = (EDGE_AW > RP_AW) ? EDGE_AW : RP_AW;

  localparam int MUL_A_W = WGT_W;
  localparam int MUL_B_W = ACC_W / 2;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [IDX_W-1:0] IDX_MAX_NODES = IDX_W'(MAX_NODES);
  localparam logic [IDX_W-1:0] IDX_MAX_EDGES = IDX_W'(MAX_EDGES);

  localparam logic [KIND_W-1:0] KIND_A_ROWPTR = 3'd0;
  localparam logic [KIND_W-1:0] KIND_A_COLUMN = 3'd1;
  localparam logic [KIND_W-1:0] KIND_A_WEIGHT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_B_ROWPTR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_B_COLUMN = 3'd4;
  localparam logic [KIND_W-1:0] KIND_B_WEIGHT = 3'd5;
  localparam logic [KIND_W-1:0] KIND_COMPUTE  = 3'd6;

  typedef struct packed {
    logic                    rp_we;
    logic                    col_we;
    logic                    w_we;
    logic [WR_AW-1:0]        addr;
    logic [IDX_W-1:0]        value;
    logic signed [WGT_W-1:0] weight;
  } gr_wr_t;

  typedef struct packed {
    logic               rp_re;
    logic               col_re;
    logic               w_re;
    logic [RP_AW-1:0]   rp_addr;
    logic [EDGE_AW-1:0] col_addr;
    logic [NODE_AW-1:0] w_addr;
  } gr_rd_t;

endpackage

### hdl/cwda_graph.sv
// One CSR graph store: row pointer, column index and node weight memories.
module cwda_graph (
  input  logic                             clk_i,
  input  cwda_pkg::gr_wr_t                 wr_i,
  input  cwda_pkg::gr_rd_t                 rd_i,
  output logic [cwda_pkg::IDX_W-1:0]       rp_o,
  output logic [cwda_pkg::IDX_W-1:0]       col_o,
  output logic signed [cwda_pkg::WGT_W-1:0] w_o
);
  import cwda_pkg::*;

  logic [IDX_W-1:0]        rp_mem  [MAX_NODES+1];
  logic [IDX_W-1:0]        col_mem [MAX_EDGES];
  logic signed [WGT_W-1:0] w_mem   [MAX_NODES];

  always_ff @(posedge clk_i) begin
    if (wr_i.rp_we) begin
      rp_mem[wr_i.addr[RP_AW-1:0]] <= wr_i.value;
    end
    if (rd_i.rp_re) begin
      rp_o <= rp_mem[rd_i.rp_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.col_we) begin
      col_mem[wr_i.addr[EDGE_AW-1:0]] <= wr_i.value;
    end
    if (rd_i.col_re) begin
      col_o <= col_mem[rd_i.col_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.w_we) begin
      w_mem[wr_i.addr[NODE_AW-1:0]] <= wr_i.weight;
    end
    if (rd_i.w_re) begin
      w_o <= w_mem[rd_i.w_addr];
    end
  end

endmodule

### hdl/cwda_mul.sv
// Shared unsigned multiplier with a registered product, used for both halves of the sum.
module cwda_mul (
  input  logic                          clk_i,
  input  logic [cwda_pkg::MUL_A_W-1:0]  a_i,
  input  logic [cwda_pkg::MUL_B_W-1:0]  b_i,
  output logic [cwda_pkg::MUL_P_W-1:0]  p_o
);
  import cwda_pkg::*;

  always_ff @(posedge clk_i) begin
    p_o <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

endmodule

### hdl/csr_weighted_diag_aba_top.sv
// Top level of the CSR weighted diagonal block: sequencer, accumulator and output stage.
//
// Load transfers (kinds 0 to 5) write one entry of graph A or B and finish in the
// cycle they are accepted; busy stays low. A compute transfer (kind 6) names a row r
// and raises busy until its single result has been produced. The sequencer walks row r
// of A one edge at a time and, for each in-range neighbour m, scans row m of B for
// column r one stored entry at a time, stopping at the first hit or the end of row m.
// Every memory has one registered read port. The closing multiply splits the sum into
// two 24-bit halves that pass through one shared 32 by 24 multiplier. The result appears
// on row_o, diag_value_o and saturated_o for exactly one cycle with valid_o high. There
// is no backpressure: the receiver must take the result in that cycle. A compute transfer
// for a row at or beyond the node limit, and a transfer of kind 7, produce no result and
// leave busy low.
module csr_weighted_diag_aba_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [cwda_pkg::KIND_W-1:0]       kind_i,
  input  logic [cwda_pkg::IDX_W-1:0]        index_i,
  input  logic [cwda_pkg::IDX_W-1:0]        index_value_i,
  input  logic signed [cwda_pkg::WGT_W-1:0] weight_i,
  output logic                              valid_o,
  output logic [cwda_pkg::ROW_W-1:0]        row_o,
  output logic signed [cwda_pkg::WGT_W-1:0] diag_value_o,
  output logic                              saturated_o
);
  import cwda_pkg::*;

  // Sequencer state codes.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_A1   = 4'd1;
  localparam logic [3:0] S_A2   = 4'd2;
  localparam logic [3:0] S_AE   = 4'd3;
  localparam logic [3:0] S_AC   = 4'd4;
  localparam logic [3:0] S_B0   = 4'd5;
  localparam logic [3:0] S_B1   = 4'd6;
  localparam logic [3:0] S_BE   = 4'd7;
  localparam logic [3:0] S_BC   = 4'd8;
  localparam logic [3:0] S_M0   = 4'd9;
  localparam logic [3:0] S_M1   = 4'd10;
  localparam logic [3:0] S_M2   = 4'd11;
  localparam logic [3:0] S_M3   = 4'd12;
  localparam logic [3:0] S_M4   = 4'd13;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [63:0] LIM_POS = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] LIM_NEG = 64'h0000_0000_8000_0000;

  logic [3:0] state_q, state_d;

  // Walk registers.
  logic [NODE_AW-1:0]      r_q, r_d;
  logic [NODE_AW-1:0]      m_q, m_d;
  logic [IDX_W-1:0]        e_q, e_d;
  logic [IDX_W-1:0]        a_end_q, a_end_d;
  logic [IDX_W-1:0]        f_q, f_d;
  logic [IDX_W-1:0]        b_end_q, b_end_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;

  // Multiply and rounding registers.
  logic [MUL_A_W-1:0]  ma_q, ma_d;
  logic [ACC_W-1:0]    ms_q, ms_d;
  logic                neg_q, neg_d;
  logic [MUL_P_W-1:0]  pl_q, pl_d;
  logic [63:0]         mag_q, mag_d;

  // Output stage.
  logic                    valid_q, valid_d;
  logic [ROW_W-1:0]        row_q, row_d;
  logic signed [WGT_W-1:0] diag_q, diag_d;
  logic                    sat_q, sat_d;

  gr_wr_t a_wr, b_wr;
  gr_rd_t a_rd, b_rd;
  logic [IDX_W-1:0]        a_rp, a_col, b_rp, b_col;
  logic signed [WGT_W-1:0] a_w, b_w;

  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  logic accept;
  logic [IDX_W-1:0]        rp_clamp_a, rp_clamp_b;
  logic signed [ACC_W:0]   acc_sum;
  logic [MUL_P_W:0]        pl_round;
  logic                    neg_eff;
  logic [63:0]             lim;
  logic                    over;
  logic [63:0]             mag_clip;
  logic [63:0]             mag_neg;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // Load decode: a load writes in the cycle it is accepted, out-of-range positions drop.
  always_comb begin
    a_wr        = '0;
    b_wr        = '0;
    a_wr.addr   = index_i[WR_AW-1:0];
    a_wr.value  = index_value_i;
    a_wr.weight = weight_i;
    b_wr.addr   = index_i[WR_AW-1:0];
    b_wr.value  = index_value_i;
    b_wr.weight = weight_i;
    if (accept) begin
      a_wr.rp_we  = (kind_i == KIND_A_ROWPTR) && (index_i <= IDX_MAX_NODES);
      a_wr.col_we = (kind_i == KIND_A_COLUMN) && (index_i < IDX_MAX_EDGES);
      a_wr.w_we   = (kind_i == KIND_A_WEIGHT) && (index_i < IDX_MAX_NODES);
      b_wr.rp_we  = (kind_i == KIND_B_ROWPTR) && (index_i <= IDX_MAX_NODES);
      b_wr.col_we = (kind_i == KIND_B_COLUMN) && (index_i < IDX_MAX_EDGES);
      b_wr.w_we   = (kind_i == KIND_B_WEIGHT) && (index_i < IDX_MAX_NODES);
    end
  end

  // A row walk never runs past the edge store, so end pointers are clamped to its size.
  assign rp_clamp_a = (a_rp > IDX_MAX_EDGES) ? IDX_MAX_EDGES : a_rp;
  assign rp_clamp_b = (b_rp > IDX_MAX_EDGES) ? IDX_MAX_EDGES : b_rp;

  // The running sum saturates to the 48-bit signed range.
  assign acc_sum = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(b_w);

  // Rounding: add one half of the dropped 16 bits to the low partial product.
  assign pl_round = {1'b0, pl_q} + (MUL_P_W+1)'(16'h8000);

  // The shared multiplier sees the low half of the sum first, then the high half.
  assign mul_b = (state_q == S_M1) ? ms_q[MUL_B_W-1:0] : ms_q[ACC_W-1:MUL_B_W];

  // Final clip: a zero magnitude is never negative.
  assign neg_eff  = neg_q && (mag_q != 64'd0);
  assign lim      = neg_eff ? LIM_NEG : LIM_POS;
  assign over     = (mag_q > lim);
  assign mag_clip = over ? lim : mag_q;
  assign mag_neg  = -mag_clip;

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    m_d     = m_q;
    e_d     = e_q;
    a_end_d = a_end_q;
    f_d     = f_q;
    b_end_d = b_end_q;
    acc_d   = acc_q;
    ma_d    = ma_q;
    ms_d    = ms_q;
    neg_d   = neg_q;
    pl_d    = pl_q;
    mag_d   = mag_q;
    valid_d = 1'b0;
    row_d   = row_q;
    diag_d  = diag_q;
    sat_d   = sat_q;
    a_rd    = '0;
    b_rd    = '0;

    case (state_q)
      S_IDLE: begin
        if (accept && (kind_i == KIND_COMPUTE) && (index_i < IDX_MAX_NODES)) begin
          r_d          = index_i[NODE_AW-1:0];
          acc_d        = '0;
          a_rd.rp_re   = 1'b1;
          a_rd.rp_addr = RP_AW'(index_i[NODE_AW-1:0]);
          a_rd.w_re    = 1'b1;
          a_rd.w_addr  = index_i[NODE_AW-1:0];
          state_d      = S_A1;
        end
      end
      S_A1: begin
        e_d          = a_rp;
        a_rd.rp_re   = 1'b1;
        a_rd.rp_addr = RP_AW'(r_q) + RP_AW'(1);
        state_d      = S_A2;
      end
      S_A2: begin
        a_end_d = rp_clamp_a;
        state_d = S_AE;
      end
      S_AE: begin
        if (e_q < a_end_q) begin
          a_rd.col_re   = 1'b1;
          a_rd.col_addr = e_q[EDGE_AW-1:0];
          state_d       = S_AC;
        end else begin
          state_d = S_M0;
        end
      end
      S_AC: begin
        if (a_col >= IDX_MAX_NODES) begin
          // Neighbour outside the node range contributes nothing.
          e_d     = e_q + IDX_W'(1);
          state_d = S_AE;
        end else begin
          m_d          = a_col[NODE_AW-1:0];
          b_rd.rp_re   = 1'b1;
          b_rd.rp_addr = RP_AW'(a_col[NODE_AW-1:0]);
          b_rd.w_re    = 1'b1;
          b_rd.w_addr  = a_col[NODE_AW-1:0];
          state_d      = S_B0;
        end
      end
      S_B0: begin
        f_d          = b_rp;
        b_rd.rp_re   = 1'b1;
        b_rd.rp_addr = RP_AW'(m_q) + RP_AW'(1);
        state_d      = S_B1;
      end
      S_B1: begin
        b_end_d = rp_clamp_b;
        state_d = S_BE;
      end
      S_BE: begin
        if (f_q < b_end_q) begin
          b_rd.col_re   = 1'b1;
          b_rd.col_addr = f_q[EDGE_AW-1:0];
          state_d       = S_BC;
        end else begin
          e_d     = e_q + IDX_W'(1);
          state_d = S_AE;
        end
      end
      S_BC: begin
        if (b_col == IDX_W'(r_q)) begin
          if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            acc_d = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
          end else begin
            acc_d = acc_sum[ACC_W-1:0];
          end
          e_d     = e_q + IDX_W'(1);
          state_d = S_AE;
        end else begin
          f_d     = f_q + IDX_W'(1);
          state_d = S_BE;
        end
      end
      S_M0: begin
        ma_d    = a_w[WGT_W-1] ? MUL_A_W'(-a_w) : MUL_A_W'(a_w);
        ms_d    = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
        neg_d   = a_w[WGT_W-1] != acc_q[ACC_W-1];
        state_d = S_M1;
      end
      S_M1: begin
        state_d = S_M2;
      end
      S_M2: begin
        pl_d    = mul_p;
        state_d = S_M3;
      end
      S_M3: begin
        mag_d   = {mul_p, 8'd0} + 64'(pl_round[MUL_P_W:16]);
        state_d = S_M4;
      end
      S_M4: begin
        valid_d = 1'b1;
        row_d   = ROW_W'(r_q);
        diag_d  = neg_eff ? mag_neg[WGT_W-1:0] : mag_clip[WGT_W-1:0];
        sat_d   = over;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q     <= r_d;
    m_q     <= m_d;
    e_q     <= e_d;
    a_end_q <= a_end_d;
    f_q     <= f_d;
    b_end_q <= b_end_d;
    acc_q   <= acc_d;
    ma_q    <= ma_d;
    ms_q    <= ms_d;
    neg_q   <= neg_d;
    pl_q    <= pl_d;
    mag_q   <= mag_d;
    row_q   <= row_d;
    diag_q  <= diag_d;
    sat_q   <= sat_d;
  end

  cwda_graph u_graph_a (
    .clk_i (clk_i),
    .wr_i  (a_wr),
    .rd_i  (a_rd),
    .rp_o  (a_rp),
    .col_o (a_col),
    .w_o   (a_w)
  );

  cwda_graph u_graph_b (
    .clk_i (clk_i),
    .wr_i  (b_wr),
    .rd_i  (b_rd),
    .rp_o  (b_rp),
    .col_o (b_col),
    .w_o   (b_w)
  );

  cwda_mul u_mul (
    .clk_i (clk_i),
    .a_i   (ma_q),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign valid_o      = valid_q;
  assign row_o        = row_q;
  assign diag_value_o = diag_q;
  assign saturated_o  = sat_q;

  // A result strobe lasts one cycle and the next result needs a full compute.
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held for more than one cycle");

  // A result only closes a busy period.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy))
    else $error("result without a preceding compute");

  // An in-range compute transfer always starts the sequencer.
  a_compute_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i == KIND_COMPUTE) && (index_i < IDX_MAX_NODES)) |=> busy)
    else $error("compute transfer did not start the walk");

  // Load transfers and unused kinds never make the block busy.
  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i != KIND_COMPUTE)) |=> (!busy && !valid_o))
    else $error("load transfer started a compute");

endmodule

### test/tb.sv
// Self-checking testbench for the CSR weighted diagonal block with directed and random graphs.
`timescale 1ns / 1ps

module tb;
  import cwda_pkg::*;

  // Kind 7 has no meaning in the block, so the package has no name for it.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

  localparam int RANDOM_ITEMS       = 400;
  localparam int SETTLE_CYCLES      = 200;
  // A compute only reads loaded entries, and this run loads at most a few hundred column
  // entries per graph, so even a row that spans all of them ends its walk well before the
  // limit below runs out, and the limit sits far above the longest such walk.
  localparam int WATCHDOG_LIMIT     = 500000;

  // The accumulator is 48 bits wide and signed.
  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;

  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic signed [WGT_W-1:0] value;
    logic                    sat;
  } diag_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [KIND_W-1:0]       kind_i;
  logic [IDX_W-1:0]        index_i;
  logic [IDX_W-1:0]        index_value_i;
  logic signed [WGT_W-1:0] weight_i;
  logic                    valid_o;
  logic [ROW_W-1:0]        row_o;
  logic signed [WGT_W-1:0] diag_value_o;
  logic                    saturated_o;

  csr_weighted_diag_aba_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .index_i       (index_i),
    .index_value_i (index_value_i),
    .weight_i      (weight_i),
    .valid_o       (valid_o),
    .row_o         (row_o),
    .diag_value_o  (diag_value_o),
    .saturated_o   (saturated_o)
  );

  // Shadow copy of both graphs. Each entry carries a flag that records whether it has been
  // written, because the block gives no meaning to an entry that was never loaded. A compute
  // is only issued when every entry it touches has been written.
  int a_row_ptr    [0:MAX_NODES];
  bit a_row_ptr_set[0:MAX_NODES];
  int a_column     [0:MAX_EDGES-1];
  bit a_column_set [0:MAX_EDGES-1];
  int a_weight     [0:MAX_NODES-1];
  bit a_weight_set [0:MAX_NODES-1];
  int b_row_ptr    [0:MAX_NODES];
  bit b_row_ptr_set[0:MAX_NODES];
  int b_column     [0:MAX_EDGES-1];
  bit b_column_set [0:MAX_EDGES-1];
  int b_weight     [0:MAX_NODES-1];
  bit b_weight_set [0:MAX_NODES-1];

  // Diagonal results that the block still owes, oldest first.
  diag_result_t expected_diags[$];
  diag_result_t want_diag;

  int  errors          = 0;
  int  items_sent      = 0;
  int  diags_predicted = 0;
  int  results_seen    = 0;
  int  stall_cycles    = 0;
  bit  gaps_on         = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Computes the diagonal entry of row r from the shadow graphs. The return value tells
  // whether every entry that the walk reads has been written.
  function automatic bit diag_of_row(input int r, output diag_result_t res);
    longint      acc;
    longint      aw;
    int          e;
    int          e_stop;
    int          f;
    int          f_stop;
    int          m;
    bit          hit;
    bit          clean;
    bit          neg;
    logic [63:0] mag_a;
    logic [63:0] mag_s;
    logic [95:0] mag;
    logic [95:0] lim;
    clean = a_row_ptr_set[r] && a_row_ptr_set[r+1] && a_weight_set[r];
    acc = 0;
    e_stop = (a_row_ptr[r+1] > MAX_EDGES) ? MAX_EDGES : a_row_ptr[r+1];
    for (e = a_row_ptr[r]; e < e_stop; e++) begin
      clean &= a_column_set[e];
      m = a_column[e];
      // A neighbour beyond the node limit contributes nothing.
      if (m < MAX_NODES) begin
        clean &= b_row_ptr_set[m] && b_row_ptr_set[m+1] && b_weight_set[m];
        f_stop = (b_row_ptr[m+1] > MAX_EDGES) ? MAX_EDGES : b_row_ptr[m+1];
        hit = 1'b0;
        // Only the first match in row m of B counts.
        for (f = b_row_ptr[m]; f < f_stop && !hit; f++) begin
          clean &= b_column_set[f];
          hit = (b_column[f] == r);
        end
        if (hit) begin
          acc += b_weight[m];
          if (acc > ACC_HI) acc = ACC_HI;
          else if (acc < ACC_LO) acc = ACC_LO;
        end
      end
    end
    // Multiply magnitudes, round half away from zero to Q16.16, then clip.
    aw = a_weight[r];
    neg = (aw < 0) != (acc < 0);
    mag_a = (aw < 0) ? -aw : aw;
    mag_s = (acc < 0) ? -acc : acc;
    mag = ((96'(mag_a) * 96'(mag_s)) + 96'h8000) >> 16;
    if (mag == 0) neg = 1'b0;
    lim = neg ? 96'h8000_0000 : 96'h7FFF_FFFF;
    res.sat = (mag > lim);
    if (res.sat) mag = lim;
    if (neg) mag = -mag;
    res.row   = ROW_W'(r);
    res.value = mag[WGT_W-1:0];
    return clean;
  endfunction

  // A weight mix: the extremes, full-range noise, and small values that do not saturate.
  function automatic int rand_weight();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return int'($urandom());
      default: return int'($urandom_range(262143)) - 131072;
    endcase
  endfunction

  // Sends one item. Fields change at the falling edge and the transfer completes at the
  // first rising edge with busy low. Start is left high afterwards, so the next call can
  // drive a fresh item at the following falling edge without lowering start in between.
  // The shadow graphs are updated and any result is predicted when the transfer happens.
  task automatic send_item(input logic [KIND_W-1:0] kind, input int idx, input int val,
                           input int w);
    diag_result_t predicted;
    bit           counts;
    counts = 1'b0;
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < 23) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start         <= 1'b1;
    kind_i        <= kind;
    index_i       <= IDX_W'(idx);
    index_value_i <= IDX_W'(val);
    weight_i      <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    case (kind)
      KIND_A_ROWPTR: if (idx <= MAX_NODES) begin
        a_row_ptr[idx] = val;
        a_row_ptr_set[idx] = 1'b1;
        counts = 1'b1;
      end
      KIND_A_COLUMN: if (idx < MAX_EDGES) begin
        a_column[idx] = val;
        a_column_set[idx] = 1'b1;
        counts = 1'b1;
      end
      KIND_A_WEIGHT: if (idx < MAX_NODES) begin
        a_weight[idx] = w;
        a_weight_set[idx] = 1'b1;
        counts = 1'b1;
      end
      KIND_B_ROWPTR: if (idx <= MAX_NODES) begin
        b_row_ptr[idx] = val;
        b_row_ptr_set[idx] = 1'b1;
        counts = 1'b1;
      end
      KIND_B_COLUMN: if (idx < MAX_EDGES) begin
        b_column[idx] = val;
        b_column_set[idx] = 1'b1;
        counts = 1'b1;
      end
      KIND_B_WEIGHT: if (idx < MAX_NODES) begin
        b_weight[idx] = w;
        b_weight_set[idx] = 1'b1;
        counts = 1'b1;
      end
      KIND_COMPUTE: if (idx < MAX_NODES) begin
        void'(diag_of_row(idx, predicted));
        expected_diags.push_back(predicted);
        diags_predicted++;
        counts = 1'b1;
      end
      default: ;
    endcase
    if (counts) items_sent++;
  endtask

  // Lowers start and holds the sender off until every owed result has arrived.
  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    do @(posedge clk_i); while (expected_diags.size() != 0 || busy);
  endtask

  // Builds a tiny graph around row 0 and checks the rounding of the closing multiply.
  // Row 0 of A has neighbour 1 and an out-of-range neighbour. Row 1 of B holds a column
  // that can never match, the hit on column 0, a second hit that must not count, and 1023.
  task automatic test_rounding();
    send_item(KIND_A_ROWPTR, 0, 0, 0);
    send_item(KIND_A_ROWPTR, 1, 2, 0);
    send_item(KIND_A_COLUMN, 0, 1, 0);
    send_item(KIND_A_COLUMN, 1, 2000, 0);
    send_item(KIND_A_WEIGHT, 0, 0, 1);
    send_item(KIND_B_ROWPTR, 1, 0, 0);
    send_item(KIND_B_ROWPTR, 2, 4, 0);
    send_item(KIND_B_COLUMN, 0, 5000, 0);
    send_item(KIND_B_COLUMN, 1, 0, 0);
    send_item(KIND_B_COLUMN, 2, 0, 0);
    send_item(KIND_B_COLUMN, 3, 1023, 0);
    send_item(KIND_B_WEIGHT, 1, 0, 32'sh0000_8000);
    // Exactly one half rounds up, and minus one half rounds down.
    send_item(KIND_COMPUTE, 0, 0, 0);
    send_item(KIND_A_WEIGHT, 0, 0, -1);
    send_item(KIND_COMPUTE, 0, 0, 0);
    wait_drained();
  endtask

  // Largest weights of equal and of opposite sign both clip.
  task automatic test_saturation();
    send_item(KIND_A_WEIGHT, 0, 0, 32'sh7FFF_FFFF);
    send_item(KIND_B_WEIGHT, 1, 0, 32'sh7FFF_FFFF);
    send_item(KIND_COMPUTE, 0, 0, 0);
    send_item(KIND_B_WEIGHT, 1, 0, 32'sh8000_0000);
    send_item(KIND_COMPUTE, 0, 0, 0);
    wait_drained();
  endtask

  // An empty row, a reversed row, and the last row whose walk ends at the edge limit.
  // The last one lands exactly on the most negative value, which must not clip.
  task automatic test_row_shapes();
    send_item(KIND_A_ROWPTR, 2, 2, 0);
    send_item(KIND_A_WEIGHT, 1, 0, 32'sh0003_0000);
    send_item(KIND_COMPUTE, 1, 0, 0);
    send_item(KIND_A_ROWPTR, 2, 1, 0);
    send_item(KIND_COMPUTE, 1, 0, 0);
    send_item(KIND_A_ROWPTR, MAX_NODES - 1, MAX_EDGES - 1, 0);
    send_item(KIND_A_ROWPTR, MAX_NODES, MAX_EDGES, 0);
    send_item(KIND_A_COLUMN, MAX_EDGES - 1, 1, 0);
    send_item(KIND_A_WEIGHT, MAX_NODES - 1, 0, 32'sh0001_0000);
    send_item(KIND_COMPUTE, MAX_NODES - 1, 0, 0);
    wait_drained();
  endtask

  // Loads beyond the store sizes, kind 7 and computes beyond the node limit change nothing;
  // a final compute of row 0 shows that the graph is intact.
  task automatic test_ignored_items();
    send_item(KIND_A_ROWPTR, MAX_NODES + 1, 7, 0);
    send_item(KIND_A_COLUMN, MAX_EDGES, 3, 0);
    send_item(KIND_A_WEIGHT, MAX_NODES, 0, 32'sh1234_5678);
    send_item(KIND_B_ROWPTR, MAX_EDGES, 5, 0);
    send_item(KIND_B_COLUMN, MAX_EDGES, 0, 0);
    send_item(KIND_B_WEIGHT, MAX_NODES, 0, -5);
    send_item(KIND_UNUSED, 0, 3, 0);
    send_item(KIND_COMPUTE, MAX_NODES, 0, 0);
    send_item(KIND_COMPUTE, MAX_EDGES, 0, 0);
    send_item(KIND_COMPUTE, 0, 0, 0);
    wait_drained();
  endtask

  // Each round builds a fresh neighbourhood for one row in both graphs and computes it if
  // all its entries are loaded. Rounds overlap in the stores, so later rounds rewrite parts
  // of earlier rows, and a few rounds also throw in noise transfers of any kind and position.
  task automatic test_random_graphs();
    diag_result_t scratch;
    int           nbrs[$];
    int           built_rows[$];
    int           base_items;
    int           round_no;
    int           r;
    int           m;
    int           da;
    int           db;
    int           a_base;
    int           a_end;
    int           b_base;
    int           j;
    int           col;
    int           noise_idx;
    logic [KIND_W-1:0] noise_kind;
    base_items = items_sent;
    round_no = 0;
    while (items_sent < base_items + RANDOM_ITEMS) begin
      round_no++;
      // A long stretch of back-to-back transfers in the middle of the run.
      gaps_on = !(round_no >= 10 && round_no < 20);
      // Once, the sender holds off until the block has delivered everything.
      if (round_no == 5) wait_drained();

      if ($urandom_range(5) == 0) begin
        repeat ($urandom_range(3, 1)) begin
          noise_kind = KIND_W'($urandom_range(7));
          noise_idx  = $urandom_range(MAX_EDGES);
          if (noise_kind == KIND_COMPUTE && noise_idx < MAX_NODES &&
              !diag_of_row(noise_idx, scratch))
            noise_idx = $urandom_range(MAX_EDGES, MAX_NODES);
          send_item(noise_kind, noise_idx, $urandom_range(MAX_EDGES), int'($urandom()));
        end
      end

      case ($urandom_range(9))
        0:       r = MAX_NODES - 1;
        1, 2:    r = $urandom_range(MAX_NODES - 1);
        default: r = $urandom_range(31);
      endcase
      da = $urandom_range(5);
      if ($urandom_range(9) == 0) a_base = MAX_EDGES - da;
      else if ($urandom_range(1)) a_base = $urandom_range(64, 3);
      else a_base = $urandom_range(8000, 3);
      // Now and then the row pointers are reversed and the row has no edges.
      a_end = ($urandom_range(9) == 0) ? a_base - $urandom_range(3, 1) : a_base + da;
      send_item(KIND_A_ROWPTR, r, a_base, 0);
      send_item(KIND_A_ROWPTR, r + 1, a_end, 0);
      nbrs.delete();
      for (j = 0; j < a_end - a_base; j++) begin
        case ($urandom_range(9))
          0:       m = $urandom_range(MAX_EDGES, MAX_NODES);
          1:       m = r;
          2:       m = $urandom_range(MAX_NODES - 1);
          default: m = $urandom_range(31);
        endcase
        send_item(KIND_A_COLUMN, a_base + j, m, 0);
        if (m < MAX_NODES) nbrs.push_back(m);
      end
      send_item(KIND_A_WEIGHT, r, 0, rand_weight());

      foreach (nbrs[k]) begin
        m  = nbrs[k];
        db = $urandom_range(4);
        b_base = $urandom_range(1) ? $urandom_range(64) : $urandom_range(MAX_EDGES - db);
        send_item(KIND_B_ROWPTR, m, b_base, 0);
        send_item(KIND_B_ROWPTR, m + 1, b_base + db, 0);
        for (j = 0; j < db; j++) begin
          case ($urandom_range(9))
            0, 1, 2, 3: col = r;
            4:          col = $urandom_range(MAX_EDGES, MAX_NODES);
            default:    col = $urandom_range(31);
          endcase
          send_item(KIND_B_COLUMN, b_base + j, col, 0);
        end
        send_item(KIND_B_WEIGHT, m, 0, rand_weight());
      end

      // A neighbour row written later can move the end of an earlier one onto entries
      // that were never loaded; such a row is left alone.
      if (diag_of_row(r, scratch)) begin
        send_item(KIND_COMPUTE, r, 0, 0);
        built_rows.push_back(r);
      end
      if ($urandom_range(1) && built_rows.size() != 0) begin
        r = built_rows[$urandom_range(built_rows.size() - 1)];
        if (diag_of_row(r, scratch)) send_item(KIND_COMPUTE, r, 0, 0);
      end
    end
    gaps_on = 1'b1;
    wait_drained();
  endtask

  // Every strobed result is compared field by field against the oldest prediction. The
  // receiver cannot stall, so a result is taken in the one cycle it is shown.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      results_seen++;
      if (expected_diags.size() == 0) begin
        errors++;
        $display("%0t: unexpected result row %0d value %h saturated %b", $time, row_o,
                 diag_value_o, saturated_o);
      end else begin
        want_diag = expected_diags.pop_front();
        if (row_o !== want_diag.row) begin
          errors++;
          $display("%0t: row mismatch: expected %0d, actual %0d", $time, want_diag.row,
                   row_o);
        end
        if (diag_value_o !== want_diag.value) begin
          errors++;
          $display("%0t: diag_value mismatch on row %0d: expected %h, actual %h", $time,
                   want_diag.row, want_diag.value, diag_value_o);
        end
        if (saturated_o !== want_diag.sat) begin
          errors++;
          $display("%0t: saturated mismatch on row %0d: expected %b, actual %b", $time,
                   want_diag.row, want_diag.sat, saturated_o);
        end
      end
    end
  end

  // Ends the run when neither an input transfer nor a result has happened for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               stall_cycles, expected_diags.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    kind_i        = KIND_A_ROWPTR;
    index_i       = '0;
    index_value_i = '0;
    weight_i      = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_rounding();
    test_saturation();
    test_row_shapes();
    test_ignored_items();
    test_random_graphs();

    // Give a stray late result the chance to show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Covered %0d load and compute transfers and %0d diagonal results,", items_sent,
             results_seen);
    $display("from rounding, clipping and row shapes to randomly built graph pairs.");
    if (errors == 0 && expected_diags.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
hdl/cwda_pkg.sv
hdl/cwda_graph.sv
hdl/cwda_mul.sv
hdl/csr_weighted_diag_aba_top.sv
test/tb.sv
